// File: hdl/fpts_pkg.sv
// fpts_pkg: shared constants, types and reset tables for the task scheduler
// no dependencies
package fpts_pkg;

  localparam int NUM_TASKS  = 5;
  localparam int TIME_BITS  = 32;
  localparam int TASK_W     = $clog2(NUM_TASKS);
  localparam int DISPATCH_W = 3;
  localparam int PRIO_W     = 16;
  localparam int LIMIT_W    = 20;
  localparam int PERIOD_W   = 8;
  localparam int FAULT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int CMP_W      = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [TIME_BITS-1:0]     time_t;
  typedef logic [LIMIT_W-1:0]       limit_t;
  typedef logic [PERIOD_W-1:0]      period_t;
  typedef logic [TASK_W-1:0]        task_t;

  localparam prio_t PRIO_REALTIME = -16'sd100;
  localparam prio_t PRIO_CEIL     = 16'sd100;
  localparam prio_t PRIO_FLOOR    = -16'sd32768;

  localparam int TASK_PRI  = 0;
  localparam int TASK_UART = 1;
  localparam int TASK_GEN  = 2;
  localparam int TASK_CTRL = 3;
  localparam int TASK_FIB  = 4;

  localparam int NUM_LIMIT_REGS = 5;
  localparam logic [CFG_IDX_W-1:0] REG_PRI_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIB_PERIOD = 3'd6;

  localparam period_t PRI_PERIOD_RESET = 8'd2;
  localparam period_t FIB_PERIOD_RESET = 8'd10;

  localparam logic REQ_SCHEDULE   = 1'b0;
  localparam logic REQ_COMPLETION = 1'b1;

  typedef struct packed {
    limit_t [NUM_TASKS-1:0] limit;
    period_t                pri_period;
    period_t                fib_period;
  } cfg_t;

  typedef struct packed {
    logic  req_type;
    logic  timer_fired;
    logic  uart_pending;
    time_t now_tick;
    logic  finished;
    time_t yield_tick;
  } req_t;

  typedef struct packed {
    logic                  dispatch_valid;
    logic [DISPATCH_W-1:0] dispatch_task;
    logic                  halted;
    logic [FAULT_W-1:0]    fault_count;
  } rsp_t;

  function automatic prio_t prio_reset(input int t);
    prio_t p;
    case (t)
      0:       p = -16'sd100;
      1:       p = -16'sd30;
      2:       p = 16'sd10;
      default: p = 16'sd0;
    endcase
    return p;
  endfunction

  function automatic limit_t limit_reset(input int t);
    limit_t l;
    case (t)
      0:       l = 20'd268100;
      1:       l = 20'd40000;
      2:       l = 20'd48000;
      3:       l = 20'd48000;
      4:       l = 20'd78580;
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

// File: hdl/fpts_if.sv
// fpts_if: channel interfaces for request, response and register writes
// depends on fpts_pkg
interface fpts_req_if
  import fpts_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  req_type;
  logic  timer_fired;
  logic  uart_pending;
  time_t now_tick;
  logic  finished;
  time_t yield_tick;

  modport source(output valid, req_type, timer_fired, uart_pending, now_tick,
                 finished, yield_tick, input ready);
  modport sink(input valid, req_type, timer_fired, uart_pending, now_tick,
               finished, yield_tick, output ready);
endinterface

interface fpts_rsp_if
  import fpts_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  dispatch_valid;
  logic [DISPATCH_W-1:0] dispatch_task;
  logic                  halted;
  logic [FAULT_W-1:0]    fault_count;

  modport source(output valid, dispatch_valid, dispatch_task, halted, fault_count,
                 input ready);
  modport sink(input valid, dispatch_valid, dispatch_task, halted, fault_count,
               output ready);
endinterface

interface fpts_cfg_if
  import fpts_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/fpts_cfg_regs.sv
// fpts_cfg_regs: execution limits and release periods, written over the config channel
// depends on fpts_pkg and fpts_if
module fpts_cfg_regs
  import fpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fpts_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        regs.limit[t] <= limit_reset(t);
      end
      regs.pri_period <= PRI_PERIOD_RESET;
      regs.fib_period <= FIB_PERIOD_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PRI_PERIOD) begin
        regs.pri_period <= cfg.data[PERIOD_W-1:0];
      end else if (cfg.index == REG_FIB_PERIOD) begin
        regs.fib_period <= cfg.data[PERIOD_W-1:0];
      end else begin
        for (int t = 0; t < NUM_TASKS; t++) begin
          if (t < NUM_LIMIT_REGS && cfg.index == CFG_IDX_W'(t)) begin
            regs.limit[t] <= cfg.data[LIMIT_W-1:0];
          end
        end
      end
    end
  end

endmodule

// File: hdl/fpts_select.sv
// fpts_select: picks the waiting task of lowest run priority, lowest index on ties
// depends on fpts_pkg
module fpts_select
  import fpts_pkg::*;
(
  input  logic [NUM_TASKS-1:0]  waiting,
  input  prio_t [NUM_TASKS-1:0] run_prio,
  output logic                  found,
  output task_t                 chosen
);

  prio_t best;

  always_comb begin
    found  = 1'b0;
    chosen = '0;
    best   = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (waiting[t] && (!found || $signed(run_prio[t]) < $signed(best))) begin
        found  = 1'b1;
        chosen = task_t'(t);
        best   = run_prio[t];
      end
    end
  end

endmodule

// File: hdl/fpts_core.sv
// fpts_core: task state, release, dispatch, retirement and overrun checking
// depends on fpts_pkg and fpts_select
module fpts_core
  import fpts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t item,
  input  cfg_t regs,
  output rsp_t result
);

  logic [NUM_TASKS-1:0]  waiting, waiting_next;
  prio_t [NUM_TASKS-1:0] base_prio, base_prio_next;
  prio_t [NUM_TASKS-1:0] run_prio, run_prio_next;
  time_t [NUM_TASKS-1:0] rel_time, rel_time_next;
  logic [NUM_TASKS-1:0]  overrun, overrun_next;
  period_t               pri_phase, pri_phase_next;
  period_t               fib_phase, fib_phase_next;
  time_t                 last_timer, last_timer_next;
  task_t                 running, running_next;
  logic                  halt, halt_next;
  logic [FAULT_W-1:0]    faults, faults_next;

  time_t [NUM_TASKS-1:0] elapsed;
  period_t               pri_inc, fib_inc;
  logic                  sched_go;
  logic                  sel_found;
  task_t                 sel_task;
  prio_t                 bp;
  logic                  of;

  always_comb begin
    for (int t = 0; t < NUM_TASKS; t++) begin
      elapsed[t] = item.yield_tick - rel_time[t];
    end
  end

  assign pri_inc  = pri_phase + 1'b1;
  assign fib_inc  = fib_phase + 1'b1;
  assign sched_go = fire && !halt && item.req_type == REQ_SCHEDULE;

  always_comb begin
    waiting_next    = waiting;
    base_prio_next  = base_prio;
    run_prio_next   = run_prio;
    rel_time_next   = rel_time;
    overrun_next    = overrun;
    pri_phase_next  = pri_phase;
    fib_phase_next  = fib_phase;
    last_timer_next = last_timer;
    halt_next       = halt;
    faults_next     = faults;
    bp              = '0;
    of              = 1'b0;
    if (fire && !halt) begin
      if (item.req_type == REQ_SCHEDULE) begin
        if (item.timer_fired) begin
          last_timer_next = item.now_tick;
          waiting_next[TASK_CTRL]  = 1'b1;
          run_prio_next[TASK_CTRL] = base_prio[TASK_CTRL];
          rel_time_next[TASK_CTRL] = item.now_tick;
          waiting_next[TASK_GEN]   = 1'b1;
          run_prio_next[TASK_GEN]  = base_prio[TASK_GEN];
          rel_time_next[TASK_GEN]  = item.now_tick;
          pri_phase_next = pri_inc;
          if (pri_inc >= regs.pri_period) begin
            pri_phase_next = '0;
            waiting_next[TASK_PRI]  = 1'b1;
            run_prio_next[TASK_PRI] = base_prio[TASK_PRI];
            rel_time_next[TASK_PRI] = item.now_tick;
          end
          fib_phase_next = fib_inc;
          if (fib_inc >= regs.fib_period) begin
            fib_phase_next = '0;
            waiting_next[TASK_FIB]  = 1'b1;
            run_prio_next[TASK_FIB] = base_prio[TASK_FIB];
            rel_time_next[TASK_FIB] = item.now_tick;
          end
        end
        if (item.uart_pending) begin
          waiting_next[TASK_UART]  = 1'b1;
          run_prio_next[TASK_UART] = base_prio[TASK_UART];
          rel_time_next[TASK_UART] = last_timer_next;
        end
      end else begin
        if (item.finished && waiting[running]) begin
          bp = base_prio[running];
          of = overrun[running];
          if (of && $signed(bp) > $signed(PRIO_FLOOR)) begin
            bp = bp - prio_t'(1);
          end
          if (CMP_W'(elapsed[running]) < CMP_W'(regs.limit[running] >> 1)) begin
            of = 1'b1;
            if ($signed(bp) < $signed(PRIO_CEIL)) begin
              bp = bp + prio_t'(1);
            end
          end
          if (of) begin
            faults_next = faults + 1'b1;
          end
          base_prio_next[running] = bp;
          overrun_next[running]   = 1'b0;
          waiting_next[running]   = 1'b0;
        end
        for (int t = 0; t < NUM_TASKS; t++) begin
          if (waiting_next[t] && CMP_W'(elapsed[t]) > CMP_W'(regs.limit[t])) begin
            if (base_prio[t] == PRIO_REALTIME) begin
              halt_next = 1'b1;
            end else begin
              overrun_next[t] = 1'b1;
            end
          end
        end
      end
    end
  end

  fpts_select u_select (
    .waiting  (waiting_next),
    .run_prio (run_prio_next),
    .found    (sel_found),
    .chosen   (sel_task)
  );

  assign running_next = (sched_go && sel_found) ? sel_task : running;

  always_comb begin
    result.dispatch_valid = sched_go && sel_found;
    result.dispatch_task  = (sched_go && sel_found) ? DISPATCH_W'(sel_task) : '0;
    result.halted         = halt_next;
    result.fault_count    = faults_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        base_prio[t] <= prio_reset(t);
        run_prio[t]  <= prio_reset(t);
      end
      waiting    <= '0;
      rel_time   <= '0;
      overrun    <= '0;
      pri_phase  <= '0;
      fib_phase  <= '0;
      last_timer <= '0;
      running    <= '0;
      halt       <= 1'b0;
      faults     <= '0;
    end else begin
      waiting    <= waiting_next;
      base_prio  <= base_prio_next;
      run_prio   <= run_prio_next;
      rel_time   <= rel_time_next;
      overrun    <= overrun_next;
      pri_phase  <= pri_phase_next;
      fib_phase  <= fib_phase_next;
      last_timer <= last_timer_next;
      running    <= running_next;
      halt       <= halt_next;
      faults     <= faults_next;
    end
  end

endmodule

// File: hdl/feedback_priority_task_scheduler.sv
// feedback_priority_task_scheduler: five-task scheduler with feedback priorities
// response is valid once the request has passed the input register and then the result register
// one request per cycle unless rsp stalls, all task updates done in one pass over five entries
// reset (rst, synchronous): task state, priorities, phases, halt and fault count
// return to their initial values, registers to their defaults, both stages empty
// depends on fpts_pkg, fpts_if, fpts_cfg_regs, fpts_core
module feedback_priority_task_scheduler
  import fpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fpts_req_if.sink   req,
  fpts_rsp_if.source rsp,
  fpts_cfg_if.sink   cfg
);

  cfg_t regs;
  req_t item;
  logic item_valid;
  logic advance;
  rsp_t result;
  rsp_t rsp_data;
  logic rsp_valid;

  assign advance   = item_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.req_type     <= req.req_type;
      item.timer_fired  <= req.timer_fired;
      item.uart_pending <= req.uart_pending;
      item.now_tick     <= req.now_tick;
      item.finished     <= req.finished;
      item.yield_tick   <= req.yield_tick;
    end
  end

  fpts_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  fpts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .regs   (regs),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.dispatch_valid = rsp_data.dispatch_valid;
  assign rsp.dispatch_task  = rsp_data.dispatch_task;
  assign rsp.halted         = rsp_data.halted;
  assign rsp.fault_count    = rsp_data.fault_count;

endmodule

// File: dv/sched_tb_pkg.sv
// sched_tb_pkg: scoreboard for the feedback priority task scheduler, holding a
// cycle-free predictor of dispatch, halt and fault count plus the queue of expected responses
// depends on fpts_pkg
package sched_tb_pkg;
  import fpts_pkg::*;

  class dispatch_scoreboard;
    limit_t             limit[NUM_TASKS];
    period_t            pri_period;
    period_t            fib_period;
    bit                 waiting[NUM_TASKS];
    prio_t              base_prio[NUM_TASKS];
    prio_t              run_prio[NUM_TASKS];
    time_t              rel_time[NUM_TASKS];
    bit                 overrun[NUM_TASKS];
    period_t            pri_phase;
    period_t            fib_phase;
    time_t              last_tick;
    int                 running;
    bit                 halted;
    logic [FAULT_W-1:0] faults;
    rsp_t               expected_q[$];
    int                 errors;

    function void reset_state();
      limit      = '{20'd268100, 20'd40000, 20'd48000, 20'd48000, 20'd78580};
      base_prio  = '{-16'sd100, -16'sd30, 16'sd10, 16'sd0, 16'sd0};
      run_prio   = base_prio;
      pri_period = 8'd2;
      fib_period = 8'd10;
      for (int t = 0; t < NUM_TASKS; t++) begin
        waiting[t]  = 1'b0;
        rel_time[t] = '0;
        overrun[t]  = 1'b0;
      end
      pri_phase = '0;
      fib_phase = '0;
      last_tick = '0;
      running   = 0;
      halted    = 1'b0;
      faults    = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx < NUM_LIMIT_REGS) begin
        limit[idx] = d;
      end else if (idx == REG_PRI_PERIOD) begin
        pri_period = d[PERIOD_W-1:0];
      end else if (idx == REG_FIB_PERIOD) begin
        fib_period = d[PERIOD_W-1:0];
      end
    endfunction

    function void launch_task(int t, time_t when);
      waiting[t]  = 1'b1;
      run_prio[t] = base_prio[t];
      rel_time[t] = when;
    endfunction

    function time_t ran_for(int t, time_t when);
      return when - rel_time[t];
    endfunction

    function void retire(int t, time_t when);
      time_t ran;
      ran = ran_for(t, when);
      waiting[t] = 1'b0;
      if (overrun[t] && base_prio[t] > PRIO_FLOOR) base_prio[t] -= 16'sd1;
      if (ran < time_t'(limit[t] >> 1)) begin
        overrun[t] = 1'b1;
        if (base_prio[t] < PRIO_CEIL) base_prio[t] += 16'sd1;
      end
      if (overrun[t]) begin
        faults     = faults + 1'b1;
        overrun[t] = 1'b0;
      end
    endfunction

    // true when this completion would raise the master fault
    function bit would_halt(req_t r);
      bit w;
      if (halted || r.req_type == REQ_SCHEDULE) return 1'b0;
      for (int t = 0; t < NUM_TASKS; t++) begin
        w = waiting[t] && !(r.finished && t == running);
        if (w && ran_for(t, r.yield_tick) > limit[t] && base_prio[t] == PRIO_REALTIME)
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      bit   found;
      int   pick;
      found = 1'b0;
      pick  = 0;
      if (!halted) begin
        if (r.req_type == REQ_SCHEDULE) begin
          if (r.timer_fired) begin
            last_tick = r.now_tick;
            launch_task(TASK_CTRL, last_tick);
            launch_task(TASK_GEN, last_tick);
            pri_phase = pri_phase + 8'd1;
            if (pri_phase >= pri_period) begin
              pri_phase = '0;
              launch_task(TASK_PRI, last_tick);
            end
            fib_phase = fib_phase + 8'd1;
            if (fib_phase >= fib_period) begin
              fib_phase = '0;
              launch_task(TASK_FIB, last_tick);
            end
          end
          if (r.uart_pending) launch_task(TASK_UART, last_tick);
          for (int t = 0; t < NUM_TASKS; t++) begin
            if (waiting[t] && (!found || run_prio[t] < run_prio[pick])) begin
              found = 1'b1;
              pick  = t;
            end
          end
          if (found) running = pick;
        end else begin
          if (r.finished && waiting[running]) retire(running, r.yield_tick);
          for (int t = 0; t < NUM_TASKS; t++) begin
            if (waiting[t] && ran_for(t, r.yield_tick) > limit[t]) begin
              if (base_prio[t] == PRIO_REALTIME) halted = 1'b1;
              else overrun[t] = 1'b1;
            end
          end
        end
      end
      e.dispatch_valid = found;
      e.dispatch_task  = found ? pick[DISPATCH_W-1:0] : '0;
      e.halted         = halted;
      e.fault_count    = faults;
      expected_q.push_back(e);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: response with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("dispatch_valid", e.dispatch_valid, got.dispatch_valid);
      check_field("dispatch_task", e.dispatch_task, got.dispatch_task);
      check_field("halted", e.halted, got.halted);
      check_field("fault_count", e.fault_count, got.fault_count);
    endfunction
  endclass

endpackage

// File: dv/tb.sv
// tb: drives schedule and completion requests and register writes into the scheduler,
// with random idling on both channels, and checks every response against the scoreboard
// depends on fpts_pkg, fpts_if, sched_tb_pkg and feedback_priority_task_scheduler
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpts_pkg::*;
  import sched_tb_pkg::*;

  logic clk;
  logic rst;

  fpts_req_if req_ch ();
  fpts_rsp_if rsp_ch ();
  fpts_cfg_if cfg_ch ();

  feedback_priority_task_scheduler DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  dispatch_scoreboard sched_sb;
  int    send_idle_pct;
  int    recv_stall_pct;
  time_t clock_now;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : rsp_monitor
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.dispatch_valid = rsp_ch.dispatch_valid;
      got.dispatch_task  = rsp_ch.dispatch_task;
      got.halted         = rsp_ch.halted;
      got.fault_count    = rsp_ch.fault_count;
      sched_sb.check_response(got);
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic req_t sched_item(bit timer, bit uart, time_t now);
    req_t r;
    r              = '0;
    r.req_type     = REQ_SCHEDULE;
    r.timer_fired  = timer;
    r.uart_pending = uart;
    r.now_tick     = now;
    return r;
  endfunction

  function automatic req_t done_item(bit fin, time_t stop);
    req_t r;
    r            = '0;
    r.req_type   = REQ_COMPLETION;
    r.finished   = fin;
    r.yield_tick = stop;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.req_type     = 1'($urandom_range(0, 1));
    r.timer_fired  = 1'($urandom_range(0, 1));
    r.uart_pending = 1'($urandom_range(0, 1));
    r.now_tick     = $urandom;
    r.finished     = 1'($urandom_range(0, 1));
    r.yield_tick   = $urandom;
    return r;
  endfunction

  // a completion that would halt too early becomes a bare schedule step
  task automatic send_req(input req_t r, input bit halt_ok);
    req_t item;
    item = r;
    if (!halt_ok && sched_sb.would_halt(item)) begin
      item.req_type     = REQ_SCHEDULE;
      item.timer_fired  = 1'b0;
      item.uart_pending = 1'b0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= item.req_type;
    req_ch.timer_fired  <= item.timer_fired;
    req_ch.uart_pending <= item.uart_pending;
    req_ch.now_tick     <= item.now_tick;
    req_ch.finished     <= item.finished;
    req_ch.yield_tick   <= item.yield_tick;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sched_sb.note_request(item);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sched_sb.write_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and wait for every outstanding response
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sched_sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input int k);
    limit_t  lim;
    period_t pp;
    period_t fp;
    settle();
    for (int t = 0; t < NUM_LIMIT_REGS; t++) begin
      case (k)
        0:       lim = '1;
        1:       lim = '0;
        default: lim = $urandom_range(0, 1) ? limit_t'($urandom)
                                            : limit_t'($urandom_range(500, 300000));
      endcase
      write_cfg(CFG_IDX_W'(t), lim);
    end
    case (k)
      0: begin
        pp = 8'd255;
        fp = 8'd255;
      end
      1, 8: begin
        pp = 8'd1;
        fp = 8'd1;
      end
      default: begin
        pp = $urandom_range(0, 1) ? period_t'($urandom_range(1, 255))
                                  : period_t'($urandom_range(1, 12));
        fp = $urandom_range(0, 1) ? period_t'($urandom_range(1, 255))
                                  : period_t'($urandom_range(1, 12));
      end
    endcase
    write_cfg(REG_PRI_PERIOD, CFG_DATA_W'(pp));
    write_cfg(REG_FIB_PERIOD, CFG_DATA_W'(fp));
  endtask

  task automatic run_phase(input int n);
    int     sent;
    bit     paused;
    req_t   r;
    limit_t lim;
    time_t  span;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (!paused && sent >= n / 2) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 12) begin
        send_req(random_req(), 1'b0);
        sent++;
      end else begin
        // tick, a few idle schedule steps, then completions of the dispatched task
        r = sched_item($urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0, clock_now);
        r.finished   = 1'($urandom_range(0, 1));
        r.yield_tick = $urandom;
        send_req(r, 1'b0);
        sent++;
        clock_now += $urandom_range(0, 70000);
        repeat ($urandom_range(0, 2)) begin
          send_req(sched_item(1'b0, $urandom_range(0, 3) == 0, $urandom), 1'b0);
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          lim = sched_sb.limit[sched_sb.running];
          case ($urandom_range(0, 4))
            0:       span = $urandom_range(0, lim >> 1);
            1:       span = $urandom_range(lim >> 1, lim);
            2:       span = lim + $urandom_range(0, 2);
            3:       span = lim + 1 + $urandom_range(0, 100000);
            default: span = $urandom;
          endcase
          r = done_item($urandom_range(0, 6) != 0, sched_sb.rel_time[sched_sb.running] + span);
          r.timer_fired  = 1'($urandom_range(0, 1));
          r.uart_pending = 1'($urandom_range(0, 1));
          r.now_tick     = $urandom;
          send_req(r, 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int rt;
    int cur;
    sched_sb = new;
    sched_sb.reset_state();
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_SCHEDULE;
    req_ch.timer_fired  = 1'b0;
    req_ch.uart_pending = 1'b0;
    req_ch.now_tick     = '0;
    req_ch.finished     = 1'b0;
    req_ch.yield_tick   = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: empty completion, empty schedule, serial release, wrapping times
    send_req(done_item(1'b1, '1), 1'b0);
    send_req(sched_item(1'b0, 1'b0, '0), 1'b0);
    send_req(sched_item(1'b0, 1'b1, '1), 1'b0);
    send_req(sched_item(1'b1, 1'b0, 32'hFFFF_FF00), 1'b0);
    send_req(done_item(1'b1, 32'h0000_0010), 1'b0);
    send_req(sched_item(1'b1, 1'b1, 32'h0000_0100), 1'b0);
    send_req(done_item(1'b1, 32'h0000_0100 + 268100), 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_req(sched_item(1'b1, i[0], time_t'(32'h0004_0000 * (i + 1))), 1'b0);
      cur = sched_sb.running;
      send_req(done_item(i % 3 != 0,
                         sched_sb.rel_time[cur] + ((i % 2) ? sched_sb.limit[cur] + 1 : 0)),
               1'b0);
    end

    clock_now = $urandom;
    for (int k = 0; k < 8; k++) begin
      apply_setting(k);
      case (k % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      run_phase(228);
    end

    // drive some task down to the realtime priority, then let it overrun
    apply_setting(8);
    for (int guard = 0; guard < 600 && !sched_sb.halted; guard++) begin
      rt = -1;
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (rt < 0 && sched_sb.waiting[t] && sched_sb.base_prio[t] == PRIO_REALTIME) rt = t;
      end
      cur = sched_sb.running;
      if (rt >= 0) begin
        send_req(done_item(1'b0, sched_sb.rel_time[rt] + sched_sb.limit[rt] + 1), 1'b1);
      end else if (sched_sb.waiting[cur] && sched_sb.overrun[cur]) begin
        send_req(done_item(1'b1, sched_sb.rel_time[cur] + sched_sb.limit[cur]), 1'b1);
      end else if (sched_sb.waiting[cur]) begin
        send_req(done_item(1'b0, sched_sb.rel_time[cur] + sched_sb.limit[cur] + 1), 1'b1);
      end else begin
        send_req(sched_item(1'b1, 1'b1, clock_now), 1'b1);
        clock_now += 1000;
      end
    end
    repeat (8) send_req(random_req(), 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (sched_sb.errors == 0 && sched_sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: feedback_priority_task_scheduler.f
hdl/fpts_pkg.sv
hdl/fpts_if.sv
hdl/fpts_cfg_regs.sv
hdl/fpts_select.sv
hdl/fpts_core.sv
hdl/feedback_priority_task_scheduler.sv
dv/sched_tb_pkg.sv
dv/tb.sv
